### rtl/core/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared operation codes, status codes, controller states and the command
// and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

  typedef enum logic [2:0] {
    FN_ADD  = 3'd0,
    FN_MUL  = 3'd1,
    FN_DIV  = 3'd2,
    FN_EQ   = 3'd3,
    FN_NEG  = 3'd4,
    FN_ISN  = 3'd5,
    FN_RED  = 3'd6,
    FN_NONE = 3'd7
  } func_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_SUM,
    S_GSTART,
    S_GWAIT,
    S_QNSTART,
    S_QNWAIT,
    S_QDSTART,
    S_QDWAIT,
    S_OUT
  } state_t;

  // Datapath commands from the controller
  typedef struct packed {
    logic       load;      // capture input word
    logic [1:0] mul_sel;   // which product to form (0..2)
    logic       mul_go;    // register product for mul_sel
    logic       sum_go;    // form final num/den and checks
    logic       g_init;    // start gcd: p=|n|, q=|d|
    logic       div_start; // start divider on current operands
    logic [1:0] div_mode;  // 0 gcd step, 1 n/g, 2 d/g
    logic       div_take;  // accept divider result
    logic       out_load;  // load output register
  } cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic [2:0] func;
    logic       skip_red;  // no reduction needed
    logic       q_zero;    // gcd loop finished
    logic       div_done;
  } sts_t;

endpackage

### rtl/core/rau_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_divider #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  always_comb begin
    shifted = {r_r, q_r[W-1]};
    trial   = shifted - {1'b0, d_r};
  end

  // One shift-subtract step per cycle
  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = shifted[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

### rtl/core/rau_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic datapath
// Operand registers, four 32x32 partial products per cycle with summation
// in the next cycle, range checks, gcd registers and the shared divider.
// ----------------------------------------------------------------------------
module rau_datapath
  import rau_pkg::*;
#(
  parameter int W = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [2:0]  in_func,
  input  logic [63:0] in_an,
  input  logic [63:0] in_ad,
  input  logic [63:0] in_bn,
  input  logic [63:0] in_bd,
  output logic [63:0] o_num,
  output logic [63:0] o_den,
  output logic        o_flag,
  output logic [1:0]  o_status
);

  localparam logic [W-1:0] LIM = {1'b0, {(W-1){1'b1}}};

  // Operand registers as sign/magnitude
  logic [2:0]   func_r;
  logic         an_s_r, ad_s_r, bn_s_r, bd_s_r;
  logic [W-1:0] an_m_r, ad_m_r, bn_m_r, bd_m_r;

  function automatic logic [W:0] to_sm(input logic [63:0] raw);
    logic [W-1:0] v;
    logic [W-1:0] m;
    begin
      v = raw[W-1:0];
      m = v[W-1] ? (~v + 1'b1) : v;
      to_sm = {v[W-1] && (m != '0), m};
    end
  endfunction

  function automatic logic fits(input logic s, input logic [W-1:0] m);
    begin
      fits = s ? ((m - 1'b1) <= LIM) : (m <= LIM);
    end
  endfunction

  function automatic logic [63:0] to_bits(input logic s, input logic [W-1:0] m);
    logic [W-1:0] v;
    begin
      v = s ? (~m + 1'b1) : m;
      to_bits = 64'(signed'(v));
    end
  endfunction

  // Multiplier: one product per step through 4 32x32 sub-products is too
  // wide a path to leave unregistered at W=64, so the product is split over two registers:
  // partials here, summation in the next cycle.
  logic [W-1:0]  mx, my;
  logic          ms;
  logic [63:0]   mxe, mye;
  logic [63:0]   pll, plh, phl, phh;
  logic [63:0]   pll_r, plh_r, phl_r, phh_r;
  logic          pvalid_r;
  logic [1:0]    psel_r;
  logic          ps_r;

  always_comb begin
    unique case (cmd.mul_sel)
      2'd0: begin
        unique case (func_t'(func_r))
          FN_MUL: begin mx = an_m_r; my = bn_m_r; ms = an_s_r ^ bn_s_r; end
          FN_DIV: begin mx = an_m_r; my = bd_m_r; ms = an_s_r ^ bd_s_r; end
          FN_ISN: begin mx = an_m_r; my = ad_m_r; ms = an_s_r ^ ad_s_r; end
          default: begin mx = bn_m_r; my = ad_m_r; ms = bn_s_r ^ ad_s_r; end
        endcase
      end
      2'd1: begin
        unique case (func_t'(func_r))
          FN_MUL: begin mx = ad_m_r; my = bd_m_r; ms = ad_s_r ^ bd_s_r; end
          FN_DIV: begin mx = ad_m_r; my = bn_m_r; ms = ad_s_r ^ bn_s_r; end
          default: begin mx = bd_m_r; my = an_m_r; ms = bd_s_r ^ an_s_r; end
        endcase
      end
      default: begin mx = bd_m_r; my = ad_m_r; ms = bd_s_r ^ ad_s_r; end
    endcase
    mxe = 64'(mx);
    mye = 64'(my);
    pll = mxe[31:0]  * mye[31:0];
    plh = mxe[31:0]  * mye[63:32];
    phl = mxe[63:32] * mye[31:0];
    phh = mxe[63:32] * mye[63:32];
  end

  // Summation of partials; any bit above the value width is overflow
  logic [63:0] mid, hi, lo;
  logic        pm_s;
  logic [W-1:0] pm_m;
  logic        pm_ovf;
  always_comb begin
    mid = {32'd0, pll_r[63:32]} + {32'd0, plh_r[31:0]} + {32'd0, phl_r[31:0]};
    hi  = phh_r + {32'd0, plh_r[63:32]} + {32'd0, phl_r[63:32]} + {32'd0, mid[63:32]};
    lo  = {mid[31:0], pll_r[31:0]};
    pm_m = lo[W-1:0];
    pm_s = ps_r && (pm_m != '0);
    pm_ovf = (hi != '0) || ((lo >> W) != '0) || !fits(pm_s, pm_m);
  end

  // Product registers t1, t2, t4
  logic         t1_s_r, t2_s_r, t4_s_r;
  logic [W-1:0] t1_m_r, t2_m_r, t4_m_r;
  logic         ovf_r;

  // Final fraction to reduce and result state
  logic         n_s_r, d_s_r;
  logic [W-1:0] n_m_r, d_m_r;
  logic         skip_r;
  logic         flag_r;
  logic [1:0]   st_r;
  logic [W-1:0] p_r, q_r;

  // Sum of t1 and t2 for add
  logic [W:0]   sum_w;
  logic         s_s;
  logic [W-1:0] s_m;
  logic         s_ovf;
  always_comb begin
    s_ovf = 1'b0;
    if (t1_s_r == t2_s_r) begin
      sum_w = {1'b0, t1_m_r} + {1'b0, t2_m_r};
      s_ovf = sum_w[W];
      s_m   = sum_w[W-1:0];
      s_s   = t1_s_r;
    end else if (t1_m_r >= t2_m_r) begin
      sum_w = '0;
      s_m   = t1_m_r - t2_m_r;
      s_s   = t1_s_r;
    end else begin
      sum_w = '0;
      s_m   = t2_m_r - t1_m_r;
      s_s   = t2_s_r;
    end
    s_s = s_s && (s_m != '0);
    s_ovf = s_ovf || !fits(s_s, s_m);
  end

  // Divider
  logic         dv_done;
  logic [W-1:0] dv_q, dv_r;
  logic [W-1:0] dv_a, dv_b;
  always_comb begin
    unique case (cmd.div_mode)
      2'd1:    begin dv_a = n_m_r; dv_b = p_r; end
      2'd2:    begin dv_a = d_m_r; dv_b = p_r; end
      default: begin dv_a = p_r;   dv_b = q_r; end
    endcase
  end

  rau_divider #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dv_a),
    .divisor  (dv_b),
    .done     (dv_done),
    .quot     (dv_q),
    .rem      (dv_r)
  );

  logic [W:0] sa, sad, sbn, sbd;
  logic       neg_s;
  always_comb begin
    sa  = to_sm(in_an);
    sad = to_sm(in_ad);
    sbn = to_sm(in_bn);
    sbd = to_sm(in_bd);
    neg_s = !an_s_r && (an_m_r != '0);
  end

  // Pick the fraction to reduce and settle non-reduced results
  logic         sel_flag;
  logic [1:0]   sel_st;
  logic         sel_skip;
  logic         sel_ns, sel_ds;
  logic [W-1:0] sel_nm, sel_dm;
  always_comb begin
    sel_flag = 1'b0;
    sel_st   = ST_OK;
    sel_skip = 1'b1;
    sel_ns   = 1'b0; sel_nm = '0;
    sel_ds   = 1'b0; sel_dm = '0;
    case (func_t'(func_r))
      FN_ADD: begin
        if (ovf_r || s_ovf) sel_st = ST_OVF;
        else begin
          sel_ns = s_s; sel_nm = s_m; sel_ds = t4_s_r; sel_dm = t4_m_r;
          sel_skip = 1'b0;
        end
      end
      FN_MUL, FN_DIV: begin
        if (func_t'(func_r) == FN_DIV && bn_m_r == '0) sel_st = ST_DIV0;
        else if (ovf_r) sel_st = ST_OVF;
        else begin
          sel_ns = t1_s_r; sel_nm = t1_m_r; sel_ds = t2_s_r; sel_dm = t2_m_r;
          sel_skip = 1'b0;
        end
      end
      FN_EQ: begin
        if (ovf_r) sel_st = ST_OVF;
        else sel_flag = (t1_s_r == t2_s_r) && (t1_m_r == t2_m_r);
      end
      FN_NEG: begin
        if (!fits(neg_s, an_m_r)) sel_st = ST_OVF;
        else begin
          sel_ns = neg_s; sel_nm = an_m_r; sel_ds = ad_s_r; sel_dm = ad_m_r;
        end
      end
      FN_ISN: begin
        if (ovf_r) sel_st = ST_OVF;
        else sel_flag = t1_s_r;
      end
      FN_RED: begin
        sel_ns = an_s_r; sel_nm = an_m_r; sel_ds = ad_s_r; sel_dm = ad_m_r;
        sel_skip = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvalid_r <= 1'b0;
    end else begin
      pvalid_r <= cmd.mul_go;
    end
    if (cmd.load) begin
      func_r <= in_func;
      {an_s_r, an_m_r} <= sa;
      {ad_s_r, ad_m_r} <= sad;
      {bn_s_r, bn_m_r} <= sbn;
      {bd_s_r, bd_m_r} <= sbd;
      ovf_r  <= 1'b0;
    end
    // Partial-product stage
    if (cmd.mul_go) begin
      pll_r <= pll; plh_r <= plh; phl_r <= phl; phh_r <= phh;
      ps_r <= ms; psel_r <= cmd.mul_sel;
    end
    // Product collection
    if (pvalid_r) begin
      if (pm_ovf) ovf_r <= 1'b1;
      unique case (psel_r)
        2'd0:    begin t1_s_r <= pm_s; t1_m_r <= pm_m; end
        2'd1:    begin t2_s_r <= pm_s; t2_m_r <= pm_m; end
        default: begin t4_s_r <= pm_s; t4_m_r <= pm_m; end
      endcase
    end
    if (cmd.sum_go) begin
      flag_r <= sel_flag;
      st_r   <= sel_st;
      skip_r <= sel_skip;
      n_s_r  <= sel_ns; n_m_r <= sel_nm;
      d_s_r  <= sel_ds; d_m_r <= sel_dm;
    end
    // Zero numerator reduces to 0/1
    if (cmd.g_init) begin
      p_r <= n_m_r;
      q_r <= d_m_r;
      if (n_m_r == '0 && !skip_r) begin
        d_s_r  <= 1'b0;
        d_m_r  <= W'(1);
      end
    end
    if (cmd.div_take) begin
      unique case (cmd.div_mode)
        2'd1:    n_m_r <= dv_q;
        2'd2:    d_m_r <= dv_q;
        default: begin p_r <= q_r; q_r <= dv_r; end
      endcase
    end
    if (cmd.out_load) begin
      o_num    <= to_bits(n_s_r && (n_m_r != '0), n_m_r);
      o_den    <= to_bits(d_s_r && (d_m_r != '0), d_m_r);
      o_flag   <= flag_r;
      o_status <= st_r;
    end
  end

  assign sts.func     = func_r;
  assign sts.skip_red = skip_r || (n_m_r == '0);
  assign sts.q_zero   = (q_r == '0);
  assign sts.div_done = dv_done;

endmodule

### rtl/core/rau_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic controller
// Sequences products, range checks, the gcd loop and the two divisions.
// ----------------------------------------------------------------------------
module rau_ctrl
  import rau_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic out_busy,
  input  sts_t sts,
  output cmd_t cmd,
  output logic idle
);

  state_t state_r, state_nxt;
  logic [1:0] nprod;

  // Number of products per operation
  always_comb begin
    case (func_t'(sts.func))
      FN_ADD:                 nprod = 2'd3;
      FN_MUL, FN_DIV, FN_EQ:  nprod = 2'd2;
      FN_ISN:                 nprod = 2'd1;
      default:                nprod = 2'd0;
    endcase
  end

  // Next state; S_MUL3 lets the last product settle before the sum
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_fire) state_nxt = S_MUL0;
      S_MUL0:    state_nxt = (nprod > 2'd1) ? S_MUL1 : S_MUL3;
      S_MUL1:    state_nxt = (nprod > 2'd2) ? S_MUL2 : S_MUL3;
      S_MUL2:    state_nxt = S_MUL3;
      S_MUL3:    state_nxt = S_SUM;
      S_SUM:     state_nxt = S_GSTART;
      S_GSTART:  state_nxt = sts.skip_red ? S_OUT : S_GWAIT;
      S_GWAIT:   begin
        if (sts.q_zero) state_nxt = S_QNSTART;
        else if (sts.div_done) state_nxt = S_GWAIT;
      end
      S_QNSTART: state_nxt = S_QNWAIT;
      S_QNWAIT:  if (sts.div_done) state_nxt = S_QDSTART;
      S_QDSTART: state_nxt = S_QDWAIT;
      S_QDWAIT:  if (sts.div_done) state_nxt = S_OUT;
      S_OUT:     if (!out_busy) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  logic gw_run_r;
  always_comb begin
    cmd = '0;
    idle = 1'b0;
    unique case (state_r)
      S_IDLE:    begin idle = 1'b1; cmd.load = in_fire; end
      S_MUL0:    begin cmd.mul_go = (nprod != 2'd0); cmd.mul_sel = 2'd0; end
      S_MUL1:    begin cmd.mul_go = 1'b1; cmd.mul_sel = 2'd1; end
      S_MUL2:    begin cmd.mul_go = (nprod > 2'd2); cmd.mul_sel = 2'd2; end
      S_SUM:     cmd.sum_go = 1'b1;
      S_GSTART:  cmd.g_init = 1'b1;
      S_GWAIT:   begin
        cmd.div_mode = 2'd0;
        cmd.div_take = sts.div_done;
        cmd.div_start = !sts.q_zero && (!gw_run_r || sts.div_done) && !sts.div_done;
      end
      S_QNSTART: begin cmd.div_mode = 2'd1; cmd.div_start = 1'b1; end
      S_QNWAIT:  begin cmd.div_mode = 2'd1; cmd.div_take = sts.div_done; end
      S_QDSTART: begin cmd.div_mode = 2'd2; cmd.div_start = 1'b1; end
      S_QDWAIT:  begin cmd.div_mode = 2'd2; cmd.div_take = sts.div_done; end
      S_OUT:     cmd.out_load = !out_busy;
      default:   ;
    endcase
  end

  // Tracks whether a gcd division is in flight
  logic gw_run_nxt;
  always_comb begin
    gw_run_nxt = gw_run_r;
    if (cmd.div_start && cmd.div_mode == 2'd0) gw_run_nxt = 1'b1;
    else if (cmd.div_take && cmd.div_mode == 2'd0) gw_run_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      gw_run_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      gw_run_r <= gw_run_nxt;
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE) else $error("load outside idle");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> state_r == S_IDLE) else $error("output not followed by idle");
  a_div_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.div_start && cmd.div_take)) else $error("divider start and take together");

endmodule

### rtl/core/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// One word in flight at a time; each gcd step and the two quotient divisions
// run on the divider one after another.
// Throughput is set by the single shared restoring divider (one bit/cycle).
// Synchronous active-low reset returns the controller to idle, output empty.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [2:0] func, [66:3] a_num, [130:67] a_den, [194:131] b_num,
  // [258:195] b_den, zero fill to 264
  input  logic [263:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [63:0] res_num, [127:64] res_den, [128] flag, [130:129] status, fill 136
  output logic [135:0] out_tdata
);

  cmd_t cmd;
  sts_t sts;
  logic idle, in_fire, ov_r;
  logic [63:0] o_num, o_den;
  logic o_flag;
  logic [1:0] o_status;

  assign in_tready = idle;
  assign in_fire   = in_tvalid && in_tready;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_busy (ov_r && !out_tready),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle)
  );

  rau_datapath #(.W(VALUE_WIDTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_func  (in_tdata[2:0]),
    .in_an    (in_tdata[66:3]),
    .in_ad    (in_tdata[130:67]),
    .in_bn    (in_tdata[194:131]),
    .in_bd    (in_tdata[258:195]),
    .o_num    (o_num),
    .o_den    (o_den),
    .o_flag   (o_flag),
    .o_status (o_status)
  );

  // Output valid register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.out_load) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, o_status, o_flag, o_den, o_num};

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |-> !cmd.out_load) else $error("output overwritten");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready) else $error("second word accepted while busy");
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("valid dropped");

endmodule

### sim/rational_arithmetic_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Watches both stream channels, computes the expected fraction, flag and
// status for every accepted input word and compares each output word with
// the oldest pending expectation.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_checker
  import rau_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [263:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [135:0] out_tdata,
  output int           fail_count,
  output int           pending_count,
  output int           op_count [8],
  output int           ovf_count,
  output int           div0_count
);

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    logic        flag;
    logic [1:0]  status;
  } frac_res_t;

  typedef struct {
    logic        neg;
    logic [63:0] mag;
  } sval_t;

  frac_res_t expected_q[$];

  function automatic sval_t make_sval(logic neg, logic [63:0] mag);
    sval_t v;
    v.mag = mag;
    v.neg = neg && (mag != 0);
    return v;
  endfunction

  function automatic sval_t to_sval(logic [63:0] raw);
    return make_sval(raw[63], raw[63] ? (~raw + 64'd1) : raw);
  endfunction

  function automatic logic [63:0] to_raw(sval_t v);
    return v.neg ? (64'd0 - v.mag) : v.mag;
  endfunction

  function automatic logic in_range(sval_t v);
    return v.neg ? (v.mag <= 64'h8000_0000_0000_0000)
                 : (v.mag <= 64'h7FFF_FFFF_FFFF_FFFF);
  endfunction

  // Exact product of magnitudes, sign from operand signs
  function automatic sval_t mul_sv(sval_t x, sval_t y, inout logic ovf);
    logic [127:0] p;
    sval_t r;
    p = x.mag * y.mag;
    r = make_sval(x.neg != y.neg, p[63:0]);
    if (p[127:64] != 0 || !in_range(r)) ovf = 1'b1;
    return r;
  endfunction

  function automatic sval_t add_sv(sval_t x, sval_t y, inout logic ovf);
    logic [64:0] s;
    sval_t r;
    if (x.neg == y.neg) begin
      s = x.mag + y.mag;
      if (s[64]) ovf = 1'b1;
      r = make_sval(x.neg, s[63:0]);
    end else if (x.mag >= y.mag) begin
      r = make_sval(x.neg, x.mag - y.mag);
    end else begin
      r = make_sval(y.neg, y.mag - x.mag);
    end
    if (!in_range(r)) ovf = 1'b1;
    return r;
  endfunction

  // Euclidean gcd reduction; each part keeps its own sign
  function automatic void reduce_sv(sval_t n, sval_t d, output sval_t rn, output sval_t rd);
    logic [63:0] p, q, t;
    if (n.mag == 0) begin
      rn = make_sval(1'b0, 64'd0);
      rd = make_sval(1'b0, 64'd1);
      return;
    end
    p = n.mag;
    q = d.mag;
    while (q != 0) begin
      t = p % q;
      p = q;
      q = t;
    end
    rn = make_sval(n.neg, n.mag / p);
    rd = make_sval(d.neg, d.mag / p);
  endfunction

  function automatic frac_res_t predict_fraction(logic [263:0] w);
    func_t fn;
    sval_t an, ad, bn, bd, rn, rd, t1, t2, t3, t4;
    logic ovf;
    frac_res_t r;
    fn = func_t'(w[2:0]);
    an = to_sval(w[66:3]);
    ad = to_sval(w[130:67]);
    bn = to_sval(w[194:131]);
    bd = to_sval(w[258:195]);
    rn = make_sval(1'b0, 64'd0);
    rd = rn;
    ovf = 1'b0;
    r = '0;
    r.status = ST_OK;
    case (fn)
      FN_ADD: begin
        t1 = mul_sv(bn, ad, ovf);
        t2 = mul_sv(bd, an, ovf);
        t3 = add_sv(t1, t2, ovf);
        t4 = mul_sv(bd, ad, ovf);
        if (!ovf) reduce_sv(t3, t4, rn, rd);
      end
      FN_MUL: begin
        t1 = mul_sv(an, bn, ovf);
        t2 = mul_sv(ad, bd, ovf);
        if (!ovf) reduce_sv(t1, t2, rn, rd);
      end
      FN_DIV: begin
        if (bn.mag == 0) begin
          r.status = ST_DIV0;
        end else begin
          t1 = mul_sv(an, bd, ovf);
          t2 = mul_sv(ad, bn, ovf);
          if (!ovf) reduce_sv(t1, t2, rn, rd);
        end
      end
      FN_EQ: begin
        t1 = mul_sv(bn, ad, ovf);
        t2 = mul_sv(bd, an, ovf);
        if (!ovf) r.flag = (t1.neg == t2.neg) && (t1.mag == t2.mag);
      end
      FN_NEG: begin
        t1 = make_sval(!an.neg, an.mag);
        if (!in_range(t1)) ovf = 1'b1;
        else begin
          rn = t1;
          rd = ad;
        end
      end
      FN_ISN: begin
        t1 = mul_sv(an, ad, ovf);
        if (!ovf) r.flag = t1.neg;
      end
      FN_RED: reduce_sv(an, ad, rn, rd);
      default: ;
    endcase
    if (ovf) begin
      r.status = ST_OVF;
      r.flag = 1'b0;
      rn = make_sval(1'b0, 64'd0);
      rd = rn;
    end
    r.num = to_raw(rn);
    r.den = to_raw(rd);
    return r;
  endfunction

  assign pending_count = expected_q.size();

  // Sample both channels at the clock edge
  always @(posedge clk) begin
    frac_res_t exp_r, got;
    if (!rst_n) begin
      fail_count <= 0;
      ovf_count <= 0;
      div0_count <= 0;
      for (int i = 0; i < 8; i++) op_count[i] <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        exp_r = predict_fraction(in_tdata);
        expected_q.push_back(exp_r);
        op_count[in_tdata[2:0]] <= op_count[in_tdata[2:0]] + 1;
        if (exp_r.status == ST_OVF) ovf_count <= ovf_count + 1;
        if (exp_r.status == ST_DIV0) div0_count <= div0_count + 1;
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[63:0], out_tdata[127:64], out_tdata[128], out_tdata[130:129]};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected output word %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.num !== exp_r.num || got.den !== exp_r.den ||
              got.flag !== exp_r.flag || got.status !== exp_r.status) begin
            $display("%0t: mismatch expected num=%h den=%h flag=%b st=%0d", $time,
                     exp_r.num, exp_r.den, exp_r.flag, exp_r.status);
            $display("%0t:          actual   num=%h den=%h flag=%b st=%0d", $time,
                     got.num, got.den, got.flag, got.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### sim/rational_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives directed and random fraction operations with random idle bursts on
// both streams and one long output stall; the checker predicts every word.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam int RANDOM_WORDS = 830;
  localparam int CYCLE_LIMIT  = 30_000_000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [263:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;

  int fail_count, pending_count, ovf_count, div0_count;
  int op_count [8];
  int cycle_count;
  bit calm_phase;
  bit long_stall_req;

  rational_arithmetic_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  rational_arithmetic_unit_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending_count(pending_count),
    .op_count(op_count), .ovf_count(ovf_count), .div0_count(div0_count)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_stall_req) begin
        out_tready <= 1'b0;
        repeat (2000) @(posedge clk);
        long_stall_req = 1'b0;
      end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Random operand biased toward small values, extremes and zero
  function automatic logic [63:0] rand_part();
    case ($urandom_range(0, 9))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return 64'd0;
      3, 4: return {$urandom, $urandom};
      5: return {{32{1'b0}}, $urandom} >> $urandom_range(0, 31);
      default: return 64'(signed'($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  task automatic send_word(func_t fn, logic [63:0] an, logic [63:0] ad,
                           logic [63:0] bn, logic [63:0] bd);
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, bd, bn, ad, an, fn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  localparam logic [63:0] MAXP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MINN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE  = 64'd1;
  localparam logic [63:0] M1   = '1;

  initial begin
    func_t fn;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    calm_phase = 1'b0;
    long_stall_req = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: each operation, extremes, special cases
    send_word(FN_ADD, 64'd1, 64'd2, 64'd1, 64'd3);
    send_word(FN_ADD, 64'd1, 64'd2, M1, 64'd2);        // zero numerator
    send_word(FN_ADD, MAXP, ONE, ONE, ONE);            // sum overflow
    send_word(FN_MUL, 64'd6, 64'd4, M1, 64'd9);
    send_word(FN_MUL, MINN, ONE, M1, ONE);             // product overflow
    send_word(FN_MUL, MINN, ONE, ONE, ONE);
    send_word(FN_DIV, 64'd3, 64'd4, 64'd0, 64'd5);     // divide by zero
    send_word(FN_DIV, MAXP, MAXP, MAXP, MAXP);         // div0 precedence n/a
    send_word(FN_DIV, 64'd3, 64'd4, -64'd9, 64'd8);
    send_word(FN_EQ, 64'd1, 64'd2, 64'd2, 64'd4);
    send_word(FN_EQ, 64'd1, 64'd2, 64'd2, 64'd5);
    send_word(FN_EQ, MINN, MINN, MAXP, MAXP);
    send_word(FN_NEG, MINN, ONE, 64'd0, 64'd0);        // negation overflow
    send_word(FN_NEG, MAXP, M1, MINN, MINN);
    send_word(FN_ISN, M1, 64'd5, 64'd0, 64'd0);
    send_word(FN_ISN, M1, M1, 64'd0, 64'd0);
    send_word(FN_ISN, 64'd0, M1, 64'd0, 64'd0);
    send_word(FN_RED, 64'd12, -64'd18, 64'd0, 64'd0);  // denominator sign kept
    send_word(FN_RED, 64'd7, 64'd0, 64'd0, 64'd0);     // zero denominator
    send_word(FN_RED, -64'd7, 64'd0, 64'd0, 64'd0);
    send_word(FN_RED, 64'd0, 64'd0, 64'd0, 64'd0);
    send_word(FN_RED, MINN, MINN, 64'd0, 64'd0);
    send_word(FN_RED, MAXP, 64'd1, 64'd0, 64'd0);
    send_word(FN_NONE, M1, M1, M1, M1);                // unused code

    // Random part; long output stall early on
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 40) long_stall_req = 1'b1;
      if (i == RANDOM_WORDS - 120) calm_phase = 1'b1;
      fn = func_t'($urandom_range(0, 7));
      send_word(fn, rand_part(), rand_part(), rand_part(), rand_part());
    end
    in_tvalid <= 1'b0;

    // Let the checker register the last accepted word first
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (500) @(posedge clk);

    $display("ops add/mul/div/eq/neg/isn/red/none: %0d %0d %0d %0d %0d %0d %0d %0d",
             op_count[0], op_count[1], op_count[2], op_count[3],
             op_count[4], op_count[5], op_count[6], op_count[7]);
    $display("overflow results %0d, divide-by-zero results %0d, mismatches %0d",
             ovf_count, div0_count, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
